// ----- rtl/core/arrc_pkg.sv -----
// Shared types, codes and helpers for the adaptive retransmit reply checker.
// No dependencies; every other file in rtl/core depends on this package.
package arrc_pkg;

   localparam int DELAY_WIDTH = 22;
   localparam int TIMEOUT_W   = 16;
   localparam int CMD_W       = 8;
   localparam int POS_W       = 32;
   localparam int SEQ_W       = 16;
   localparam int RETRY_W     = 8;
   localparam int TOTAL_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = DELAY_WIDTH;

   localparam logic [DELAY_WIDTH-1:0] DELAY_MAX = {DELAY_WIDTH{1'b1}};
   localparam logic [TOTAL_W-1:0]     TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [RETRY_W-1:0]     RETRY_MAX = {RETRY_W{1'b1}};

   localparam logic [SEQ_W-1:0] SEQ_MASK    = 16'hfff8;
   localparam logic [SEQ_W-1:0] SEQ_TOGGLE  = 16'h1080;
   localparam logic [SEQ_W-1:0] RETRY_MASK  = 16'h0007;
   localparam int               MS_PER_S    = 1000;

   // floor(n / 3) = (n * RECIP3) >> RECIP3_SHIFT for n < 2**(DELAY_WIDTH+2)
   localparam int RECIP3_SHIFT = DELAY_WIDTH + 3;
   localparam logic [RECIP3_SHIFT-1:0] RECIP3 =
      RECIP3_SHIFT'(((64'd1 << RECIP3_SHIFT) + 64'd2) / 64'd3);

   // Reset values of the registers
   localparam logic [DELAY_WIDTH-1:0] TARGET_RST    = DELAY_WIDTH'(1340);
   localparam logic [DELAY_WIDTH-1:0] MAX_RST       = DELAY_WIDTH'(300000);
   localparam logic [DELAY_WIDTH-1:0] MIN_RST       = DELAY_WIDTH'(1000);
   localparam logic [DELAY_WIDTH-1:0] STEP_RST      = DELAY_WIDTH'(1340);
   localparam logic [CMD_W-1:0]       ERROR_CMD_RST = 8'd64;

   typedef enum logic [1:0] {
      REQ_NEW     = 2'd0,
      REQ_TIMEOUT = 2'd1,
      REQ_REPLY   = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      VERDICT_SEND      = 3'd0,
      VERDICT_ACCEPTED  = 3'd1,
      VERDICT_WRONG_SEQ = 3'd2,
      VERDICT_WRONG_CMD = 3'd3,
      VERDICT_WRONG_POS = 3'd4,
      VERDICT_GAVE_UP   = 3'd5
   } verdict_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TARGET_DELAY = 3'd0,
      REG_MAX_DELAY    = 3'd1,
      REG_MIN_DELAY    = 3'd2,
      REG_STEP_DELAY   = 3'd3,
      REG_TIMEOUT      = 3'd4,
      REG_ERROR_CMD    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [SEQ_W-1:0]       random_seq;
      logic [CMD_W-1:0]       req_cmd;
      logic [POS_W-1:0]       req_pos;
      logic                   pos_checked;
      logic [SEQ_W-1:0]       reply_seq;
      logic [CMD_W-1:0]       reply_cmd;
      logic [POS_W-1:0]       reply_pos;
      logic [DELAY_WIDTH-1:0] rtt_ms;
   } req_item_type;

   typedef struct packed {
      logic [SEQ_W-1:0]       seq_word;
      logic [DELAY_WIDTH-1:0] wait_ms;
      logic [2:0]             verdict;
   } rsp_item_type;

   // Configuration as seen by the step logic; the timeout is held in ms.
   typedef struct packed {
      logic [DELAY_WIDTH-1:0] target;
      logic [DELAY_WIDTH-1:0] max_delay;
      logic [DELAY_WIDTH-1:0] min_wait;
      logic [DELAY_WIDTH-1:0] step;
      logic [TOTAL_W-1:0]     limit_ms;
      logic [CMD_W-1:0]       error_cmd;
   } cfg_type;

   typedef struct packed {
      logic [SEQ_W-1:0]       seq_base;
      logic [RETRY_W-1:0]     retry_count;
      logic [DELAY_WIDTH-1:0] busy_ms;
      logic [DELAY_WIDTH-1:0] idle_ms;
      logic [DELAY_WIDTH-1:0] last_wait;
      logic [TOTAL_W-1:0]     total_wait;
      logic [CMD_W-1:0]       saved_cmd;
      logic [POS_W-1:0]       saved_pos;
      logic                   saved_pos_check;
   } state_type;

   // Below the minimum gives the minimum, else above the maximum gives the maximum.
   function automatic logic [DELAY_WIDTH-1:0] clamp_wait(
      input logic [DELAY_WIDTH-1:0] w,
      input logic [DELAY_WIDTH-1:0] lo,
      input logic [DELAY_WIDTH-1:0] hi
   );
      logic [DELAY_WIDTH-1:0] r;
      if (w < lo) begin
         r = lo;
      end else if (w > hi) begin
         r = hi;
      end else begin
         r = w;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/arrc_req_if.sv -----
// Request channel: valid/ready handshake carrying one request item.
// Depends on arrc_pkg for the payload type.
interface arrc_req_if;
   logic                  valid;
   logic                  ready;
   arrc_pkg::req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/arrc_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one result item.
// Depends on arrc_pkg for the payload type.
interface arrc_rsp_if;
   logic                  valid;
   logic                  ready;
   arrc_pkg::rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/adaptive_retransmit_reply_checker.sv -----
// Top level of the adaptive retransmit reply checker: registers, handshakes, CSRs.
// Depends on arrc_pkg, arrc_req_if, arrc_rsp_if and arrc_step.
//
//   channel    dir  handshake        payload
//   req_chan   in   valid / ready    req_item_type (request, timeout or reply event)
//   rsp_chan   out  valid / ready    rsp_item_type (seq_word, wait_ms, verdict)
//   csr_*      in   csr_we only      csr_index selects register, csr_wdata value
//
// Each event is handled in the cycle it is transferred; its result sits in the
// output register from the next cycle. One event per cycle is sustained, limited
// only by the output register: a new event is taken whenever that register is
// empty or is being drained in the same cycle. Reset is synchronous and restores
// the CSRs, the protocol state and the output valid flag at once; no clearing pass is needed.
// An event of the unused type updates nothing and produces no result.
module adaptive_retransmit_reply_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   arrc_req_if.sink                                req_chan,
   arrc_rsp_if.source                              rsp_chan,
   input  logic                                    csr_we,
   input  logic [arrc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [arrc_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import arrc_pkg::*;

   cfg_type      cfg_ff,   cfg_in;
   state_type    state_ff, state_in;
   rsp_item_type rsp_ff,   rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   state_type    step_state;
   rsp_item_type step_rsp;
   logic         step_has_rsp;
   logic         req_xfer;

   // Take a new event whenever the output register is free or emptying
   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   arrc_step u_step (
      .cfg_i     (cfg_ff),
      .state_i   (state_ff),
      .item_i    (req_chan.payload),
      .state_o   (step_state),
      .rsp_o     (step_rsp),
      .has_rsp_o (step_has_rsp)
   );

   // CSR writes; the timeout is kept pre-scaled to milliseconds
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_DELAY: cfg_in.target    = csr_wdata[DELAY_WIDTH-1:0];
            REG_MAX_DELAY:    cfg_in.max_delay = csr_wdata[DELAY_WIDTH-1:0];
            REG_MIN_DELAY:    cfg_in.min_wait  = csr_wdata[DELAY_WIDTH-1:0];
            REG_STEP_DELAY:   cfg_in.step      = csr_wdata[DELAY_WIDTH-1:0];
            REG_TIMEOUT:      cfg_in.limit_ms  = TOTAL_W'(csr_wdata[TIMEOUT_W-1:0])
                                                 * TOTAL_W'(MS_PER_S);
            REG_ERROR_CMD:    cfg_in.error_cmd = csr_wdata[CMD_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance protocol state and load the result on a transfer
   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_xfer) begin
         state_in = step_state;
         if (step_has_rsp) begin
            rsp_in       = step_rsp;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target    <= TARGET_RST;
         cfg_ff.max_delay <= MAX_RST;
         cfg_ff.min_wait  <= MIN_RST;
         cfg_ff.step      <= STEP_RST;
         cfg_ff.limit_ms  <= '0;
         cfg_ff.error_cmd <= ERROR_CMD_RST;
         state_ff.seq_base        <= '0;
         state_ff.retry_count     <= '0;
         state_ff.busy_ms         <= TARGET_RST;
         state_ff.idle_ms         <= TARGET_RST;
         state_ff.last_wait       <= '0;
         state_ff.total_wait      <= '0;
         state_ff.saved_cmd       <= '0;
         state_ff.saved_pos       <= '0;
         state_ff.saved_pos_check <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // A new request always clears the retry count and yields a send result
   a_new_clears_retry: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_chan.payload.req_type == REQ_NEW
      |=> state_ff.retry_count == '0 && state_ff.total_wait == '0
          && rsp_valid_ff && rsp_ff.verdict == VERDICT_SEND)
      else $error("new request did not restart retry state");

   // A give-up result never carries a wait
   a_gave_up_no_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.verdict == VERDICT_GAVE_UP |-> rsp_ff.wait_ms == '0)
      else $error("give-up result with non-zero wait");

   // Reply verdicts leave the retry count and accumulated wait untouched
   a_reply_keeps_retry: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_chan.payload.req_type == REQ_REPLY
      |=> $stable(state_ff.retry_count) && $stable(state_ff.total_wait))
      else $error("reply changed retry state");

   // The low bits of the result sequence track the saturated retry count
   a_seq_low_bits: assert property (@(posedge clock) disable iff (reset)
      req_xfer && step_has_rsp
      |=> rsp_ff.seq_word[2:0] == state_ff.retry_count[2:0])
      else $error("sequence word retry bits mismatch");

   // Output register only waits while the consumer stalls
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("request stalled with empty output register");

endmodule

// ----- rtl/core/arrc_step.sv -----
// Next-state and result logic for one request item of the retransmit checker.
// Purely combinational; depends on arrc_pkg.
module arrc_step (
   input  arrc_pkg::cfg_type      cfg_i,
   input  arrc_pkg::state_type    state_i,
   input  arrc_pkg::req_item_type item_i,
   output arrc_pkg::state_type    state_o,
   output arrc_pkg::rsp_item_type rsp_o,
   output logic                   has_rsp_o
);
   import arrc_pkg::*;

   localparam int PROD_W = (DELAY_WIDTH + 2) + RECIP3_SHIFT;

   logic [SEQ_W-1:0]         seq_cand;
   logic [DELAY_WIDTH:0]     busy_step_sum;
   logic [DELAY_WIDTH-1:0]   first_wait;
   logic [DELAY_WIDTH+1:0]   busy_x3;
   logic [DELAY_WIDTH:0]     busy_half;
   logic [DELAY_WIDTH-1:0]   busy_grown;
   logic [DELAY_WIDTH+1:0]   idle_x4;
   logic [PROD_W-1:0]        idle_prod;
   logic [DELAY_WIDTH+1:0]   idle_quot;
   logic [DELAY_WIDTH-1:0]   idle_sat;
   logic [DELAY_WIDTH-1:0]   idle_grown;
   logic [TOTAL_W:0]         total_sum;
   logic [TOTAL_W-1:0]       total_next;
   logic [RETRY_W-1:0]       retry_next;
   logic [DELAY_WIDTH-1:0]   wait_val;
   logic [2:0]               verdict;
   state_type                nxt;

   // Shared arithmetic: first wait, busy growth by 3/2, idle growth by 4/3, wait total, retry count
   always_comb begin
      seq_cand      = item_i.random_seq & SEQ_MASK;
      busy_step_sum = {1'b0, state_i.busy_ms} + {1'b0, cfg_i.step};
      if (cfg_i.target >= state_i.busy_ms) begin
         first_wait = cfg_i.target;
      end else if (busy_step_sum[DELAY_WIDTH]) begin
         first_wait = DELAY_MAX;
      end else begin
         first_wait = busy_step_sum[DELAY_WIDTH-1:0];
      end

      busy_x3   = {2'b00, state_i.busy_ms} + {1'b0, state_i.busy_ms, 1'b0};
      busy_half = busy_x3[DELAY_WIDTH+1:1];
      busy_grown = busy_half[DELAY_WIDTH] ? DELAY_MAX : busy_half[DELAY_WIDTH-1:0];

      idle_x4   = {state_i.idle_ms, 2'b00};
      idle_prod = PROD_W'(idle_x4) * PROD_W'(RECIP3);
      idle_quot = idle_prod[PROD_W-1:RECIP3_SHIFT];
      idle_sat  = (idle_quot > {2'b00, DELAY_MAX}) ? DELAY_MAX
                                                   : idle_quot[DELAY_WIDTH-1:0];
      idle_grown = (idle_sat > cfg_i.max_delay) ? cfg_i.max_delay : idle_sat;

      total_sum  = {1'b0, state_i.total_wait}
                 + (TOTAL_W+1)'(state_i.last_wait);
      total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      retry_next = (state_i.retry_count == RETRY_MAX) ? RETRY_MAX
                                                      : state_i.retry_count + 1'b1;
   end

   // Per-type update
   always_comb begin
      nxt       = state_i;
      wait_val  = '0;
      verdict   = VERDICT_SEND;
      has_rsp_o = 1'b1;
      case (item_i.req_type)
         REQ_NEW: begin
            nxt.seq_base        = (seq_cand == state_i.seq_base)
                                  ? (state_i.seq_base ^ SEQ_TOGGLE) : seq_cand;
            nxt.retry_count     = '0;
            nxt.total_wait      = '0;
            nxt.saved_cmd       = item_i.req_cmd;
            nxt.saved_pos       = item_i.req_pos;
            nxt.saved_pos_check = item_i.pos_checked;
            wait_val            = clamp_wait(first_wait, cfg_i.min_wait, cfg_i.max_delay);
            nxt.last_wait       = wait_val;
         end
         REQ_TIMEOUT: begin
            nxt.retry_count = retry_next;
            nxt.total_wait  = total_next;
            if (state_i.retry_count == '0) begin
               nxt.busy_ms    = busy_grown;
               nxt.idle_ms    = busy_grown;
               wait_val       = clamp_wait(busy_grown, cfg_i.min_wait, cfg_i.max_delay);
               nxt.last_wait  = wait_val;
            end else if (cfg_i.limit_ms != '0 && total_next >= cfg_i.limit_ms) begin
               verdict = VERDICT_GAVE_UP;
            end else begin
               nxt.idle_ms    = idle_grown;
               wait_val       = clamp_wait(idle_grown, cfg_i.min_wait, cfg_i.max_delay);
               nxt.last_wait  = wait_val;
            end
         end
         REQ_REPLY: begin
            if (((item_i.reply_seq ^ state_i.seq_base) & SEQ_MASK) != '0) begin
               verdict = VERDICT_WRONG_SEQ;
            end else if (item_i.reply_cmd != state_i.saved_cmd &&
                         item_i.reply_cmd != cfg_i.error_cmd) begin
               verdict = VERDICT_WRONG_CMD;
            end else if (state_i.saved_pos_check &&
                         item_i.reply_pos != state_i.saved_pos) begin
               verdict = VERDICT_WRONG_POS;
            end else begin
               verdict        = VERDICT_ACCEPTED;
               nxt.busy_ms    = item_i.rtt_ms;
            end
         end
         default: begin
            has_rsp_o = 1'b0;
         end
      endcase

      state_o          = nxt;
      rsp_o.seq_word   = (nxt.seq_base & SEQ_MASK) | (SEQ_W'(nxt.retry_count) & RETRY_MASK);
      rsp_o.wait_ms    = wait_val;
      rsp_o.verdict    = verdict;
   end

endmodule

// ----- dv/adaptive_retransmit_reply_checker_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for adaptive_retransmit_reply_checker: bursty event driver,
// stalling result monitor and an in-bench prediction of the retransmit protocol.
// Depends on arrc_pkg, arrc_req_if, arrc_rsp_if and the block's top level.
module adaptive_retransmit_reply_checker_tb;
   import arrc_pkg::*;

   localparam logic [1:0] REQ_UNUSED  = 2'd3;      // event type the block ignores
   localparam int         SETTLE      = 4;         // cycles past the last result
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         LONG_HOLD   = 400;       // receiver hold-off length
   localparam int         SOAK_TIMEOUTS = 1030;    // enough to saturate the wait total

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_TARGET_DELAY;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   arrc_req_if req_if ();
   arrc_rsp_if rsp_if ();

   adaptive_retransmit_reply_checker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Events waiting to be offered, and the results they are owed
   req_item_type event_backlog[$];
   rsp_item_type awaited_answers[$];

   int unsigned mismatch_count = 0;
   int unsigned queued_count   = 0;
   int unsigned results_seen   = 0;
   int unsigned cycle_count    = 0;

   // Predicted configuration, as the block should hold it
   logic [DELAY_WIDTH-1:0] cfg_target  = TARGET_RST;
   logic [DELAY_WIDTH-1:0] cfg_max     = MAX_RST;
   logic [DELAY_WIDTH-1:0] cfg_min     = MIN_RST;
   logic [DELAY_WIDTH-1:0] cfg_step    = STEP_RST;
   logic [TIMEOUT_W-1:0]   cfg_timeout = '0;
   logic [CMD_W-1:0]       cfg_err     = ERROR_CMD_RST;

   // Predicted protocol state
   logic [SEQ_W-1:0]       seq_base    = '0;
   logic [RETRY_W-1:0]     retries     = '0;
   logic [DELAY_WIDTH-1:0] busy_ms     = TARGET_RST;
   logic [DELAY_WIDTH-1:0] idle_ms     = TARGET_RST;
   logic [DELAY_WIDTH-1:0] last_wait   = '0;
   logic [TOTAL_W-1:0]     total_wait  = '0;
   logic [CMD_W-1:0]       saved_cmd   = '0;
   logic [POS_W-1:0]       saved_pos   = '0;
   logic                   saved_check = 1'b0;

   // What the stimulus side knows of the request in force, so that it can
   // build replies that get past the sequence, command and position checks
   logic [SEQ_W-1:0] gen_seq = '0;
   logic [CMD_W-1:0] gen_cmd = '0;
   logic [POS_W-1:0] gen_pos = '0;
   logic             gen_chk = 1'b0;
   logic [CMD_W-1:0] gen_err = ERROR_CMD_RST;

   // Driver and monitor pacing
   int unsigned burst_left   = 0;
   int unsigned gap_left     = 0;
   int unsigned ready_mode   = 0;
   int unsigned mode_left    = 0;
   int unsigned hold_left    = 0;
   int unsigned next_hold_at = 200;

   // ---------------------------------------------------------------- prediction

   // Saturate a widened delay at the delay field maximum.
   function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [63:0] v);
      return (v > 64'(DELAY_MAX)) ? DELAY_MAX : v[DELAY_WIDTH-1:0];
   endfunction

   // Raise to the minimum first; only then cap at the maximum.
   function automatic logic [DELAY_WIDTH-1:0] bound_wait(input logic [DELAY_WIDTH-1:0] w);
      if (w < cfg_min) return cfg_min;
      if (w > cfg_max) return cfg_max;
      return w;
   endfunction

   // Advance the predicted protocol by one accepted event and queue its result.
   function automatic void absorb_event(input req_item_type ev);
      logic [SEQ_W-1:0]       pick;
      logic [DELAY_WIDTH-1:0] w;
      logic [63:0]            sum;
      verdict_type            verdict;
      rsp_item_type           answer;
      w = '0;
      verdict = VERDICT_SEND;
      case (ev.req_type)
         REQ_NEW: begin
            pick = ev.random_seq & SEQ_MASK;
            // an unchanged sequence would alias the last request: toggle it
            if (pick == seq_base) seq_base = seq_base ^ SEQ_TOGGLE;
            else seq_base = pick;
            retries     = '0;
            total_wait  = '0;
            saved_cmd   = ev.req_cmd;
            saved_pos   = ev.req_pos;
            saved_check = ev.pos_checked;
            if (cfg_target >= busy_ms) w = cfg_target;
            else w = sat_delay(64'(busy_ms) + 64'(cfg_step));
            w = bound_wait(w);
            last_wait = w;
         end
         REQ_TIMEOUT: begin
            if (retries != RETRY_MAX) retries = retries + 1'b1;
            sum = 64'(total_wait) + 64'(last_wait);
            total_wait = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (retries == RETRY_W'(1)) begin
               busy_ms = sat_delay(64'(busy_ms) * 64'd3 / 64'd2);
               idle_ms = busy_ms;
               w = bound_wait(busy_ms);
               last_wait = w;
            end else if (cfg_timeout != '0 &&
                         64'(total_wait) / 64'(MS_PER_S) >= 64'(cfg_timeout)) begin
               verdict = VERDICT_GAVE_UP;
            end else begin
               idle_ms = sat_delay(64'(idle_ms) * 64'd4 / 64'd3);
               if (idle_ms > cfg_max) idle_ms = cfg_max;
               w = bound_wait(idle_ms);
               last_wait = w;
            end
         end
         REQ_REPLY: begin
            if (((ev.reply_seq ^ seq_base) & SEQ_MASK) != '0) begin
               verdict = VERDICT_WRONG_SEQ;
            end else if (ev.reply_cmd != saved_cmd && ev.reply_cmd != cfg_err) begin
               verdict = VERDICT_WRONG_CMD;
            end else if (saved_check && ev.reply_pos != saved_pos) begin
               verdict = VERDICT_WRONG_POS;
            end else begin
               verdict = VERDICT_ACCEPTED;
               busy_ms = ev.rtt_ms;
            end
         end
         default: return;   // unused type: no change, no result
      endcase
      answer.seq_word = (seq_base & SEQ_MASK) | (SEQ_W'(retries) & RETRY_MASK);
      answer.wait_ms  = w;
      answer.verdict  = verdict;
      awaited_answers.push_back(answer);
   endfunction

   // ---------------------------------------------------------------- stimulus

   // Every field random, the type included.
   function automatic req_item_type scrambled_event();
      logic [159:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_item_type)-1:0];
   endfunction

   function automatic req_item_type make_new(input logic [SEQ_W-1:0] rs,
                                             input logic [CMD_W-1:0] c,
                                             input logic [POS_W-1:0] p,
                                             input logic chk);
      req_item_type ev;
      ev = scrambled_event();
      ev.req_type    = REQ_NEW;
      ev.random_seq  = rs;
      ev.req_cmd     = c;
      ev.req_pos     = p;
      ev.pos_checked = chk;
      return ev;
   endfunction

   function automatic req_item_type make_timeout();
      req_item_type ev;
      ev = scrambled_event();
      ev.req_type = REQ_TIMEOUT;
      return ev;
   endfunction

   function automatic req_item_type make_reply(input logic [SEQ_W-1:0] s,
                                               input logic [CMD_W-1:0] c,
                                               input logic [POS_W-1:0] p,
                                               input logic [DELAY_WIDTH-1:0] rtt);
      req_item_type ev;
      ev = scrambled_event();
      ev.req_type  = REQ_REPLY;
      ev.reply_seq = s;
      ev.reply_cmd = c;
      ev.reply_pos = p;
      ev.rtt_ms    = rtt;
      return ev;
   endfunction

   // Queue an event and track the request it sets up.
   function automatic void enqueue_event(input req_item_type ev);
      logic [SEQ_W-1:0] pick;
      if (ev.req_type == REQ_NEW) begin
         pick = ev.random_seq & SEQ_MASK;
         gen_seq = (pick == gen_seq) ? (gen_seq ^ SEQ_TOGGLE) : pick;
         gen_cmd = ev.req_cmd;
         gen_pos = ev.req_pos;
         gen_chk = ev.pos_checked;
      end
      if (ev.req_type != REQ_UNUSED) queued_count++;
      event_backlog.push_back(ev);
   endfunction

   function automatic logic [DELAY_WIDTH-1:0] random_rtt();
      if ($urandom_range(3) == 0) return DELAY_WIDTH'($urandom);
      return DELAY_WIDTH'($urandom_range(0, 5000));
   endfunction

   // One request episode: new request, a run of timeouts, then mostly a reply that
   // mostly passes; now and then pure noise instead.
   function automatic void queue_episode();
      int unsigned      n_timeouts;
      int unsigned      style;
      logic [SEQ_W-1:0] rs;
      logic [CMD_W-1:0] c;
      if ($urandom_range(9) == 0) begin
         enqueue_event(scrambled_event());
         return;
      end
      // now and then reuse the sequence in force to force the toggle
      rs = ($urandom_range(7) == 0) ? (gen_seq | SEQ_W'($urandom_range(7)))
                                    : SEQ_W'($urandom);
      enqueue_event(make_new(rs, CMD_W'($urandom), POS_W'($urandom),
                             1'($urandom_range(1))));
      n_timeouts = ($urandom_range(9) == 0) ? $urandom_range(5, 14) : $urandom_range(0, 4);
      repeat (n_timeouts) enqueue_event(make_timeout());
      style = $urandom_range(9);
      if (style <= 5) begin
         enqueue_event(make_reply((gen_seq & SEQ_MASK) | SEQ_W'($urandom_range(7)),
                                  ($urandom_range(3) == 0) ? gen_err : gen_cmd,
                                  gen_chk ? gen_pos : POS_W'($urandom), random_rtt()));
         // drop a late duplicate in after the accept now and then
         if ($urandom_range(4) == 0)
            enqueue_event(make_reply(gen_seq, gen_cmd, gen_pos, random_rtt()));
      end else if (style == 6) begin
         enqueue_event(make_reply(gen_seq ^ (SEQ_W'(8) << $urandom_range(12)),
                                  gen_cmd, gen_pos, random_rtt()));
      end else if (style == 7) begin
         c = CMD_W'($urandom);
         while (c == gen_cmd || c == gen_err) c = c + 1'b1;
         enqueue_event(make_reply(gen_seq, c, gen_pos, random_rtt()));
      end else if (style == 8) begin
         enqueue_event(make_reply(gen_seq, gen_cmd,
                                  gen_pos ^ (POS_W'(1) << $urandom_range(31)),
                                  random_rtt()));
      end
   endfunction

   // Wait until every event is transferred and every result drained, then settle.
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (event_backlog.size() != 0 || req_if.valid || awaited_answers.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_TARGET_DELAY: cfg_target = value;
         REG_MAX_DELAY:    cfg_max    = value;
         REG_MIN_DELAY:    cfg_min    = value;
         REG_STEP_DELAY:   cfg_step   = value;
         REG_TIMEOUT:      cfg_timeout = value[TIMEOUT_W-1:0];
         REG_ERROR_CMD: begin
            cfg_err = value[CMD_W-1:0];
            gen_err = cfg_err;
         end
         default: ;
      endcase
   endtask

   // Write all six registers; junk rides in the unused upper bits of the narrow ones.
   task automatic apply_settings(input logic [DELAY_WIDTH-1:0] t,
                                 input logic [DELAY_WIDTH-1:0] mx,
                                 input logic [DELAY_WIDTH-1:0] mn,
                                 input logic [DELAY_WIDTH-1:0] st,
                                 input logic [TIMEOUT_W-1:0] to,
                                 input logic [CMD_W-1:0] er);
      write_register(REG_TARGET_DELAY, t);
      write_register(REG_MAX_DELAY, mx);
      write_register(REG_MIN_DELAY, mn);
      write_register(REG_STEP_DELAY, st);
      write_register(REG_TIMEOUT, {(CSR_DATA_W-TIMEOUT_W)'($urandom), to});
      write_register(REG_ERROR_CMD, {(CSR_DATA_W-CMD_W)'($urandom), er});
   endtask

   task automatic run_random_phase(input int unsigned budget);
      int unsigned start;
      start = queued_count;
      while (queued_count - start < budget) queue_episode();
      wait_for_quiet();
   endtask

   initial begin : stimulus
      req_item_type junk;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset settings
      // reply before any request matches the cleared sequence and command
      enqueue_event(make_reply(16'h0000, 8'h00, 32'h0, 22'd0));
      enqueue_event(make_timeout());                     // timeout with nothing sent
      // sequence unchanged from reset: toggled
      enqueue_event(make_new(16'h0003, 8'hff, 32'hffff_ffff, 1'b1));
      enqueue_event(make_timeout());                     // first resend, busy grows
      enqueue_event(make_timeout());                     // later resend, idle grows
      enqueue_event(make_reply(gen_seq ^ 16'h8000, gen_cmd, gen_pos, 22'd7));
      enqueue_event(make_reply(gen_seq | 16'h0007, 8'h00, gen_pos, 22'd7));
      enqueue_event(make_reply(gen_seq, ERROR_CMD_RST, 32'h0, 22'd7));
      enqueue_event(make_reply(gen_seq | 16'h0005, ERROR_CMD_RST, gen_pos, DELAY_MAX));
      // busy now at the field maximum: step sum and 3/2 growth saturate
      enqueue_event(make_new(16'hffff, 8'h00, 32'h0, 1'b0));
      enqueue_event(make_timeout());
      enqueue_event(make_timeout());
      enqueue_event(make_reply(gen_seq, ERROR_CMD_RST, 32'h1234_5678, 22'd1000));
      enqueue_event(make_reply(gen_seq, gen_cmd, 32'hdead_beef, 22'd0));   // after accept
      junk = '1;
      junk.req_type = REQ_UNUSED;
      enqueue_event(junk);
      enqueue_event(make_new(gen_seq | 16'h0007, 8'h00, 32'h0, 1'b1));    // toggled again
      enqueue_event(make_reply(gen_seq, 8'hff, 32'h0, 22'd0));
      enqueue_event(make_reply(gen_seq, 8'h00, 32'h0, 22'd1340));
      wait_for_quiet();

      // Random part over several settings, the extremes among them
      apply_settings(TARGET_RST, MAX_RST, MIN_RST, STEP_RST, 16'd3, ERROR_CMD_RST);
      run_random_phase(80);
      apply_settings('0, '0, '0, '0, 16'd1, 8'd0);
      run_random_phase(70);
      apply_settings(DELAY_MAX, DELAY_MAX, '0, DELAY_MAX, 16'hffff, 8'hff);
      run_random_phase(70);
      // minimum above maximum: a wait below the minimum is raised to it, any other is capped at the maximum
      apply_settings(DELAY_WIDTH'($urandom_range(0, 8000)), 22'd2000, 22'd5000,
                     DELAY_WIDTH'($urandom_range(0, 8000)), 16'd0, CMD_W'($urandom));
      run_random_phase(70);
      repeat (4) begin
         apply_settings(DELAY_WIDTH'($urandom_range(0, 4000)),
                        DELAY_WIDTH'($urandom_range(500, 400000)),
                        DELAY_WIDTH'($urandom_range(0, 3000)),
                        DELAY_WIDTH'($urandom_range(0, 4000)),
                        TIMEOUT_W'($urandom_range(0, 30)), CMD_W'($urandom));
         run_random_phase(55);
      end

      // Soak: maximum waits until the retry count and the wait total saturate
      apply_settings(DELAY_MAX, DELAY_MAX, DELAY_MAX, '0, 16'd0, 8'd0);
      enqueue_event(make_new(SEQ_W'($urandom), CMD_W'($urandom), POS_W'($urandom), 1'b1));
      repeat (SOAK_TIMEOUTS) enqueue_event(make_timeout());
      enqueue_event(make_reply(gen_seq, gen_cmd, gen_pos, random_rtt()));
      wait_for_quiet();

      apply_settings(TARGET_RST, MAX_RST, MIN_RST, STEP_RST, 16'd0, ERROR_CMD_RST);
      run_random_phase(70);

      if (mismatch_count == 0 && awaited_answers.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   // Offer backlog events in bursts; a stalled transfer is held as it is.
   always @(posedge clock) begin : event_driver
      logic offer;
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         offer = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            absorb_event(req_if.payload);
            event_backlog.delete(0);
            offer = 1'b0;
         end
         if (!offer) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (event_backlog.size() != 0) begin
               offer = 1'b1;
               req_if.payload <= event_backlog[0];
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  // long bursts now and then give stretches with no idling
                  burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 250)
                                                        : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         req_if.valid <= offer;
      end
   end

   // ---------------------------------------------------------------- monitor

   // Check each result transfer against the oldest prediction, then choose
   // the next ready from a shifting pattern with an occasional long hold-off.
   always @(posedge clock) begin : result_monitor
      rsp_item_type got;
      rsp_item_type want;
      logic         next_ready;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            if (awaited_answers.size() == 0) begin
               $display("%0t: result with none awaited: seq_word %h wait_ms %0d verdict %0d",
                        $time, got.seq_word, got.wait_ms, got.verdict);
               mismatch_count++;
            end else begin
               want = awaited_answers.pop_front();
               if (got.seq_word !== want.seq_word) begin
                  $display("%0t: seq_word expected %h actual %h",
                           $time, want.seq_word, got.seq_word);
                  mismatch_count++;
               end
               if (got.wait_ms !== want.wait_ms) begin
                  $display("%0t: wait_ms expected %0d actual %0d",
                           $time, want.wait_ms, got.wait_ms);
                  mismatch_count++;
               end
               if (got.verdict !== want.verdict) begin
                  $display("%0t: verdict expected %0d actual %0d",
                           $time, want.verdict, got.verdict);
                  mismatch_count++;
               end
            end
            results_seen++;
         end

         if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (results_seen >= next_hold_at) begin
            // hold off long enough for the block to fill and stall its input
            hold_left    = LONG_HOLD;
            next_hold_at = next_hold_at + 900;
            next_ready   = 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(3);
               mode_left  = $urandom_range(5, 80);
            end
            mode_left--;
            case (ready_mode)
               0:       next_ready = 1'b1;
               1:       next_ready = ($urandom_range(3) != 0);
               2:       next_ready = 1'($urandom_range(1));
               default: next_ready = ($urandom_range(3) == 0);
            endcase
         end
         rsp_if.ready <= next_ready;
      end
   end

   // Watchdog: advance the cycle count and end a run that hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
